FILE: sv/utf8d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types, byte classes and the windows-1252 fallback table
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam int UNITS_MAX = 4;

   typedef logic [15:0] unit_type;

   // one item's worth of results: up to four code units
   typedef struct packed {
      unit_type [UNITS_MAX-1:0] units;
      logic [1:0]               last_idx;   // index of the final unit
      logic                     str_end;    // final unit ends the string
   } bundle_type;

   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_STRAY
   } class_type;

   function automatic class_type classify(input logic [7:0] b);
      class_type c;
      if (b inside {[8'h00:8'h7f]}) begin
         c = CLS_ASCII;
      end else if (b inside {[8'h80:8'hbf]}) begin
         c = CLS_CONT;
      end else if (b inside {[8'hc0:8'hdf]}) begin
         c = CLS_LEAD2;
      end else if (b inside {[8'he0:8'hef]}) begin
         c = CLS_LEAD3;
      end else if (b inside {[8'hf0:8'hf7]}) begin
         c = CLS_LEAD4;
      end else begin
         c = CLS_STRAY;
      end
      return c;
   endfunction

   // bytes 80-9f go through the windows-1252 table, others map to themselves
   function automatic unit_type fallback(input logic [7:0] b);
      unit_type u;
      if (b[7:5] == 3'b100) begin
         case (b[4:0])
            5'd0:    u = 16'd8364;
            5'd1:    u = 16'd63;
            5'd2:    u = 16'd8218;
            5'd3:    u = 16'd402;
            5'd4:    u = 16'd8222;
            5'd5:    u = 16'd8230;
            5'd6:    u = 16'd8224;
            5'd7:    u = 16'd8225;
            5'd8:    u = 16'd710;
            5'd9:    u = 16'd8240;
            5'd10:   u = 16'd352;
            5'd11:   u = 16'd8249;
            5'd12:   u = 16'd338;
            5'd13:   u = 16'd63;
            5'd14:   u = 16'd381;
            5'd15:   u = 16'd63;
            5'd16:   u = 16'd63;
            5'd17:   u = 16'd8216;
            5'd18:   u = 16'd8217;
            5'd19:   u = 16'd8220;
            5'd20:   u = 16'd8221;
            5'd21:   u = 16'd8226;
            5'd22:   u = 16'd8211;
            5'd23:   u = 16'd8212;
            5'd24:   u = 16'd732;
            5'd25:   u = 16'd8482;
            5'd26:   u = 16'd353;
            5'd27:   u = 16'd8250;
            5'd28:   u = 16'd339;
            5'd29:   u = 16'd63;
            5'd30:   u = 16'd382;
            5'd31:   u = 16'd376;
            default: u = 16'd63;
         endcase
      end else begin
         u = {8'h00, b};
      end
      return u;
   endfunction

endpackage
`default_nettype wire

FILE: sv/utf8d_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_front
// decode state and classification; builds one result bundle per input byte
// ----------------------------------------------------------------------------
module utf8d_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  is_last,
   output utf8d_pkg::bundle_type      bundle,
   output logic                       has_units
);
   import utf8d_pkg::*;

   logic [7:0] lead_ff, lead_in;
   logic [7:0] c0_ff, c0_in;
   logic [7:0] c1_ff, c1_in;
   logic [1:0] need_ff, need_in;
   logic [1:0] held_ff, held_in;

   class_type  cls;
   logic [2:0] n;
   unit_type   v;

   always_comb begin
      bundle  = '0;
      n       = 3'd0;
      v       = '0;
      lead_in = lead_ff;
      c0_in   = c0_ff;
      c1_in   = c1_ff;
      need_in = need_ff;
      held_in = held_ff;
      cls     = classify(data_byte);

      if (need_ff != 2'd0 && cls == CLS_CONT) begin
         if ({1'b0, held_ff} + 3'd1 >= {1'b0, need_ff}) begin
            case (need_ff)
               2'd1:    v = {5'b0, lead_in[4:0], data_byte[5:0]};
               2'd2:    v = {lead_ff[3:0], c0_ff[5:0], data_byte[5:0]};
               default: v = {c0_ff[3:0], c1_ff[5:0], data_byte[5:0]};
            endcase
            bundle.units[0] = v;
            n       = 3'd1;
            lead_in = '0;
            c0_in   = '0;
            c1_in   = '0;
            need_in = 2'd0;
            held_in = 2'd0;
         end else begin
            if (held_ff[0]) begin
               c1_in = data_byte;
            end else begin
               c0_in = data_byte;
            end
            held_in = held_ff + 2'd1;
         end
      end else begin
         // broken sequence: lead and held continuations fall back
         if (need_ff != 2'd0) begin
            bundle.units[n[1:0]] = fallback(lead_ff);
            n = n + 3'd1;
            if (held_ff >= 2'd1) begin
               bundle.units[n[1:0]] = fallback(c0_ff);
               n = n + 3'd1;
            end
            if (held_ff >= 2'd2) begin
               bundle.units[n[1:0]] = fallback(c1_ff);
               n = n + 3'd1;
            end
         end
         lead_in = '0;
         c0_in   = '0;
         c1_in   = '0;
         need_in = 2'd0;
         held_in = 2'd0;
         case (cls)
            CLS_ASCII: begin
               bundle.units[n[1:0]] = {8'h00, data_byte};
               n = n + 3'd1;
            end
            CLS_LEAD2: begin
               lead_in = data_byte;
               need_in = 2'd1;
            end
            CLS_LEAD3: begin
               lead_in = data_byte;
               need_in = 2'd2;
            end
            CLS_LEAD4: begin
               lead_in = data_byte;
               need_in = 2'd3;
            end
            default: begin
               bundle.units[n[1:0]] = fallback(data_byte);
               n = n + 3'd1;
            end
         endcase
      end

      // end of string flushes whatever is still held
      if (is_last) begin
         if (need_in != 2'd0) begin
            bundle.units[n[1:0]] = fallback(lead_in);
            n = n + 3'd1;
            if (held_in >= 2'd1) begin
               bundle.units[n[1:0]] = fallback(c0_in);
               n = n + 3'd1;
            end
            if (held_in >= 2'd2) begin
               bundle.units[n[1:0]] = fallback(c1_in);
               n = n + 3'd1;
            end
         end
         lead_in = '0;
         c0_in   = '0;
         c1_in   = '0;
         need_in = 2'd0;
         held_in = 2'd0;
      end

      bundle.last_idx = 2'(n - 3'd1);
      bundle.str_end  = is_last;
   end

   assign has_units = (n != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= '0;
         c0_ff   <= '0;
         c1_ff   <= '0;
         need_ff <= 2'd0;
         held_ff <= 2'd0;
      end else if (accept) begin
         lead_ff <= lead_in;
         c0_ff   <= c0_in;
         c1_ff   <= c1_in;
         need_ff <= need_in;
         held_ff <= held_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/utf8d_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_queue
// short first-in first-out queue of result bundles between front and back
// ----------------------------------------------------------------------------
module utf8d_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire utf8d_pkg::bundle_type in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output utf8d_pkg::bundle_type      out_data
);
   import utf8d_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bundle_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

FILE: sv/utf8d_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8d_back
// output register that walks a bundle out one code unit per cycle while rsp_tready is high
// ----------------------------------------------------------------------------
module utf8d_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire utf8d_pkg::bundle_type in_data,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [15:0]                rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);
   import utf8d_pkg::*;

   bundle_type cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       at_final;
   logic       take;

   assign at_final   = (idx_ff == cur_ff.last_idx);
   assign take       = rsp_tvalid && rsp_tready;
   assign in_ready   = !valid_ff || (take && at_final);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = cur_ff.units[idx_ff];
   assign rsp_tlast  = at_final;
   assign rsp_tuser  = at_final && cur_ff.str_end;

   always_comb begin
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (in_ready) begin
         // current bundle done or none held: load the next one
         cur_in   = in_data;
         idx_in   = 2'd0;
         valid_in = in_valid;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule
`default_nettype wire

FILE: sv/utf8_to_ucs2_decoder_with_fallback.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_with_fallback
// utf-8 byte stream to 16-bit code units, windows-1252 fallback on errors
// ----------------------------------------------------------------------------
// usage:
//   req channel: one string byte per item, tlast marks the final byte.
//   rsp channel: one code unit per item; tlast marks the final unit caused
//   by an input byte, tuser marks the final unit of the whole string.
//   an input byte yields zero to four code units. the front decodes one byte
//   per cycle while the queue has room and pushes its units as one bundle
//   into a queue of QUEUE_DEPTH bundles; the back register sends one unit
//   per cycle while rsp_tready is high. with the output idle, a byte's
//   bundle passes through the queue into the back register, which puts its
//   first unit on rsp. throughput: one byte per cycle while bytes yield at
//   most one unit each and rsp_tready is high; error bursts output one unit
//   per cycle, and the queue lets input continue until it holds QUEUE_DEPTH
//   bundles. when the receiver stalls, the current unit holds on rsp and
//   req_tready falls once the queue is full. reset clears the decode state,
//   the queue and the output register; no item is lost on either side.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_with_fallback #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] code_unit
   output logic             rsp_tlast,   // last_of_run
   output logic             rsp_tuser    // [0] end_of_string
);
   import utf8d_pkg::*;

   bundle_type front_bundle;
   bundle_type queue_bundle;
   logic       has_units;
   logic       accept;
   logic       queue_ready;
   logic       queue_valid;
   logic       back_ready;

   assign req_tready = queue_ready;
   assign accept     = req_tvalid && req_tready;

   utf8d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .is_last   (req_tlast),
      .bundle    (front_bundle),
      .has_units (has_units)
   );

   utf8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && has_units),
      .in_ready  (queue_ready),
      .in_data   (front_bundle),
      .out_valid (queue_valid),
      .out_ready (back_ready),
      .out_data  (queue_bundle)
   );

   utf8d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_ready   (back_ready),
      .in_data    (queue_bundle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// checks the utf-8 to ucs-2 decoder against an in-bench decode model
// ----------------------------------------------------------------------------
// a directed string hits ascii, the zero byte, every sequence length, stray
// bytes, broken sequences and a flush at the end of a string. random strings
// follow, mostly well-formed sequences with random content plus broken and
// stray bytes. both channels stall at random outside a steady run, and the
// sender pauses now and then until every expected code unit has come back.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_BYTES  = 230;
   localparam int IDLE_PERCENT  = 38;
   localparam int STALL_LIMIT   = 1000;
   localparam int DRAIN_CYCLES  = 10;
   localparam int REPORT_MAX    = 10;
   localparam int STEADY_FIRST  = 100;
   localparam int STEADY_LAST   = 160;

   // windows-1252 code units for bytes 80-9f, byte 80 in the top slot
   localparam logic [511:0] CP1252_HIGH = {
      16'd8364, 16'd63,   16'd8218, 16'd402,  16'd8222, 16'd8230, 16'd8224, 16'd8225,
      16'd710,  16'd8240, 16'd352,  16'd8249, 16'd338,  16'd63,   16'd381,  16'd63,
      16'd63,   16'd8216, 16'd8217, 16'd8220, 16'd8221, 16'd8226, 16'd8211, 16'd8212,
      16'd732,  16'd8482, 16'd353,  16'd8250, 16'd339,  16'd63,   16'd382,  16'd376
   };

   typedef enum int {
      TOK_ASCII,
      TOK_SEQ2,
      TOK_SEQ3,
      TOK_SEQ4,
      TOK_BROKEN,
      TOK_STRAY
   } token_kind_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       hold;   // wait for all code units before sending
   } byte_item_type;

   typedef struct {
      utf8d_pkg::unit_type unit;
      logic                run_end;
      logic                str_end;
   } unit_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   byte_item_type byte_queue[$];
   logic [7:0]    str_bytes[$];
   unit_item_type expected_units[$];
   utf8d_pkg::unit_type run_units[$];

   // decode state
   logic [7:0]  lead_byte = 8'h00;
   logic [7:0]  cont_bytes[2];
   logic [1:0]  conts_needed = 2'd0;
   logic [1:0]  conts_held = 2'd0;

   int          bytes_sent = 0;
   int          strings_sent = 0;
   int          units_checked = 0;
   int          fallback_units = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   utf8_to_ucs2_decoder_with_fallback dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] data_byte
      .req_tlast  (req_tlast),    // is_last
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] code_unit
      .rsp_tlast  (rsp_tlast),    // last_of_run
      .rsp_tuser  (rsp_tuser)     // [0] end_of_string
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic utf8d_pkg::unit_type fallback_unit(input logic [7:0] b);
      int slot;
      slot = 31 - int'(b[4:0]);
      if (b[7:5] == 3'b100) begin
         return CP1252_HIGH[slot*16 +: 16];
      end
      return {8'h00, b};
   endfunction

   // unfinished sequence: lead then each held continuation by fallback
   function void flush_held();
      if (conts_needed == 2'd0) begin
         return;
      end
      run_units.push_back(fallback_unit(lead_byte));
      for (int i = 0; i < int'(conts_held); i++) begin
         run_units.push_back(fallback_unit(cont_bytes[i]));
      end
      fallback_units += 1 + int'(conts_held);
      conts_needed = 2'd0;
      conts_held   = 2'd0;
   endfunction

   function void decode_byte(input logic [7:0] b, input logic last);
      logic [31:0] cp;
      run_units.delete();
      if (conts_needed != 2'd0 && (b & 8'hc0) == 8'h80) begin
         if (int'(conts_held) + 1 >= int'(conts_needed)) begin
            if (conts_needed == 2'd1) begin
               cp = (32'(lead_byte & 8'h1f) << 6) | 32'(b & 8'h3f);
            end else if (conts_needed == 2'd2) begin
               cp = (32'(lead_byte & 8'h0f) << 12) | (32'(cont_bytes[0] & 8'h3f) << 6)
                  | 32'(b & 8'h3f);
            end else begin
               cp = (32'(lead_byte & 8'h07) << 18) | (32'(cont_bytes[0] & 8'h3f) << 12)
                  | (32'(cont_bytes[1] & 8'h3f) << 6) | 32'(b & 8'h3f);
            end
            run_units.push_back(cp[15:0]);
            conts_needed = 2'd0;
            conts_held   = 2'd0;
         end else begin
            cont_bytes[conts_held[0]] = b;
            conts_held = conts_held + 2'd1;
         end
      end else begin
         flush_held();
         if (b < 8'h80) begin
            run_units.push_back({8'h00, b});
         end else if ((b & 8'he0) == 8'hc0) begin
            lead_byte = b;
            conts_needed = 2'd1;
            conts_held = 2'd0;
         end else if ((b & 8'hf0) == 8'he0) begin
            lead_byte = b;
            conts_needed = 2'd2;
            conts_held = 2'd0;
         end else if ((b & 8'hf8) == 8'hf0) begin
            lead_byte = b;
            conts_needed = 2'd3;
            conts_held = 2'd0;
         end else begin
            run_units.push_back(fallback_unit(b));
            fallback_units++;
         end
      end
      if (last) begin
         flush_held();
      end
      foreach (run_units[i]) begin
         unit_item_type u;
         u.unit    = run_units[i];
         u.run_end = (i == run_units.size() - 1);
         u.str_end = u.run_end && last;
         expected_units.push_back(u);
      end
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   function void append_token(input token_kind_type kind);
      int need;
      int keep;
      case (kind)
         TOK_ASCII: begin
            str_bytes.push_back(($urandom_range(0, 39) == 0) ? 8'h00
                                                              : 8'($urandom_range(1, 127)));
         end
         TOK_SEQ2: begin
            str_bytes.push_back(8'($urandom_range(8'hc0, 8'hdf)));
            str_bytes.push_back(cont_byte());
         end
         TOK_SEQ3: begin
            str_bytes.push_back(8'($urandom_range(8'he0, 8'hef)));
            repeat (2) str_bytes.push_back(cont_byte());
         end
         TOK_SEQ4: begin
            str_bytes.push_back(8'($urandom_range(8'hf0, 8'hf7)));
            repeat (3) str_bytes.push_back(cont_byte());
         end
         TOK_BROKEN: begin
            need = $urandom_range(1, 3);
            keep = $urandom_range(0, need - 1);
            if (need == 1) begin
               str_bytes.push_back(8'($urandom_range(8'hc0, 8'hdf)));
            end else if (need == 2) begin
               str_bytes.push_back(8'($urandom_range(8'he0, 8'hef)));
            end else begin
               str_bytes.push_back(8'($urandom_range(8'hf0, 8'hf7)));
            end
            repeat (keep) str_bytes.push_back(cont_byte());
         end
         default: begin
            str_bytes.push_back($urandom_range(0, 1) ? cont_byte()
                                                     : 8'($urandom_range(8'hf8, 8'hff)));
         end
      endcase
   endfunction

   function void queue_string(input logic hold);
      byte_item_type it;
      foreach (str_bytes[i]) begin
         it.data = str_bytes[i];
         it.last = (i == str_bytes.size() - 1);
         it.hold = hold && (i == 0);
         byte_queue.push_back(it);
      end
      str_bytes.delete();
   endfunction

   function automatic logic steady_stretch();
      return bytes_sent >= STEADY_FIRST && bytes_sent < STEADY_LAST;
   endfunction

   // driver
   always @(posedge clock) begin
      logic          send;
      byte_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tlast);
            bytes_sent++;
            if (req_tlast) begin
               strings_sent++;
            end
         end
         if (!req_tvalid || req_tready) begin
            send = byte_queue.size() != 0;
            if (send && byte_queue[0].hold && expected_units.size() != 0) begin
               send = 1'b0;
            end
            if (send && !steady_stretch() && $urandom_range(0, 99) < IDLE_PERCENT) begin
               send = 1'b0;
            end
            if (send) begin
               it = byte_queue.pop_front();
               req_tdata <= it.data;
               req_tlast <= it.last;
            end
            req_tvalid <= send;
         end
      end
   end

   // monitor, receiver stalls and watchdog
   always @(posedge clock) begin
      unit_item_type want;
      rsp_tready <= steady_stretch() || ($urandom_range(0, 99) >= IDLE_PERCENT);
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (rsp_tvalid && rsp_tready) begin
            units_checked++;
            if (expected_units.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("unexpected code unit %h tlast=%b tuser=%b",
                           rsp_tdata, rsp_tlast, rsp_tuser);
               end
            end else begin
               want = expected_units.pop_front();
               if (rsp_tdata !== want.unit || rsp_tlast !== want.run_end
                   || rsp_tuser !== want.str_end) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("code unit %0d: expected %h/%b/%b, got %h/%b/%b",
                              units_checked, want.unit, want.run_end, want.str_end,
                              rsp_tdata, rsp_tlast, rsp_tuser);
                  end
               end
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no item moved for %0d cycles, %0d code units outstanding",
                     STALL_LIMIT, expected_units.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int             string_idx;
      int             pick;
      token_kind_type kind;
      // directed string: ascii, zero byte, each sequence length, stray bytes,
      // broken sequences, unfinished sequence flushed at the end
      str_bytes = '{8'h41, 8'h00, 8'h7f,
                    8'hc3, 8'ha9,
                    8'he2, 8'h82, 8'hac,
                    8'hf0, 8'h9f, 8'h98, 8'h80,
                    8'h80, 8'hff, 8'hf8, 8'h9d, 8'ha0,
                    8'hc0, 8'h41,
                    8'hf0, 8'h9f, 8'h98, 8'h41,
                    8'he2, 8'h82};
      queue_string(1'b0);
      string_idx = 0;
      while (byte_queue.size() < RANDOM_BYTES) begin
         repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
               kind = TOK_ASCII;
            end else if (pick < 45) begin
               kind = TOK_SEQ2;
            end else if (pick < 63) begin
               kind = TOK_SEQ3;
            end else if (pick < 78) begin
               kind = TOK_SEQ4;
            end else if (pick < 90) begin
               kind = TOK_BROKEN;
            end else begin
               kind = TOK_STRAY;
            end
            append_token(kind);
         end
         queue_string(string_idx % 10 == 0);
         string_idx++;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (byte_queue.size() != 0 || req_tvalid || expected_units.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_units.size() != 0) begin
         mismatches++;
      end
      $display("decoded %0d bytes in %0d strings into %0d code units",
               bytes_sent, strings_sent, units_checked);
      $display("%0d of those units came from fallback, %0d mismatches",
               fallback_units, mismatches);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
sv/utf8d_pkg.sv
sv/utf8d_front.sv
sv/utf8d_queue.sv
sv/utf8d_back.sv
sv/utf8_to_ucs2_decoder_with_fallback.sv
dv/tb.sv
